// ----- sv/wbog_pkg.sv -----
// wbog_pkg: types, register codes and coordinate helpers for the wave block origin generator
// used by every module of the block; depends on nothing

package wbog_pkg;

	localparam int CoordWidth = 12;
	localparam int BlockStep  = 8;
	localparam int CfgWidth   = 10;
	localparam int OutWidth   = 12;
	localparam int OffWidth   = 2;
	localparam int WideWidth  = ((CoordWidth > CfgWidth + 1) ? CoordWidth : CfgWidth + 1) + 2;
	localparam int AddrWidth  = 5;
	localparam int DataWidth  = 32;
	localparam int InDataWidth  = ((3 * OffWidth + 7) / 8) * 8;
	localparam int OutDataWidth = ((3 * OutWidth + 7) / 8) * 8;

	typedef logic signed [CoordWidth-1:0] coord_t;
	typedef logic signed [WideWidth-1:0]  wide_t;
	typedef logic signed [OffWidth-1:0]   off_t;
	typedef logic [CfgWidth-1:0]          cfg_val_t;

	typedef enum logic [2:0] {
		REG_ORIGIN_X,
		REG_ORIGIN_Y,
		REG_ORIGIN_Z,
		REG_SIZE_X,
		REG_SIZE_Y,
		REG_SIZE_Z,
		REG_DIR_NEGATIVE
	} reg_idx_t;

	typedef struct packed {
		cfg_val_t origin_x;
		cfg_val_t origin_y;
		cfg_val_t origin_z;
		cfg_val_t size_x;
		cfg_val_t size_y;
		cfg_val_t size_z;
		logic     dir_negative;
	} cfg_t;

	typedef struct packed {
		logic [OutWidth-1:0] block_x;
		logic [OutWidth-1:0] block_y;
		logic [OutWidth-1:0] block_z;
		logic                batch_end;
	} res_t;

	localparam wide_t StepW = wide_t'(BlockStep);

	function automatic wide_t uext(cfg_val_t v);
		return {{(WideWidth-CfgWidth){1'b0}}, v};
	endfunction

	function automatic wide_t cext(coord_t v);
		return {{(WideWidth-CoordWidth){v[CoordWidth-1]}}, v};
	endfunction

	function automatic wide_t oext(off_t v);
		return {{(WideWidth-OffWidth){v[OffWidth-1]}}, v};
	endfunction

	function automatic coord_t front_coord(cfg_val_t origin, off_t off, cfg_val_t size);
		wide_t v;
		v = uext(origin) + oext(off);
		if (v > uext(size)) begin
			v = uext(origin);
		end
		return coord_t'(v);
	endfunction

	function automatic coord_t end_z_reset(cfg_val_t size_z, logic dir_negative);
		return dir_negative ? coord_t'(uext(size_z) - StepW) : coord_t'(StepW);
	endfunction

	function automatic logic [OutWidth-1:0] to_out(coord_t v);
		return OutWidth'(cext(v));
	endfunction

endpackage

// ----- sv/wbog_cfg.sv -----
// wbog_cfg: apb register file holding wave origin, problem size and direction
// depends on wbog_pkg

module wbog_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [wbog_pkg::AddrWidth-1:0] paddr,
	input  logic [wbog_pkg::DataWidth-1:0] pwdata,
	output logic [wbog_pkg::DataWidth-1:0] prdata,
	output logic                           pready,
	output wbog_pkg::cfg_t                 cfg
);
	import wbog_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[AddrWidth-1:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_ORIGIN_X:     cfg_q.origin_x     <= pwdata[CfgWidth-1:0];
				REG_ORIGIN_Y:     cfg_q.origin_y     <= pwdata[CfgWidth-1:0];
				REG_ORIGIN_Z:     cfg_q.origin_z     <= pwdata[CfgWidth-1:0];
				REG_SIZE_X:       cfg_q.size_x       <= pwdata[CfgWidth-1:0];
				REG_SIZE_Y:       cfg_q.size_y       <= pwdata[CfgWidth-1:0];
				REG_SIZE_Z:       cfg_q.size_z       <= pwdata[CfgWidth-1:0];
				REG_DIR_NEGATIVE: cfg_q.dir_negative <= pwdata[0];
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_ORIGIN_X:     prdata = DataWidth'(cfg_q.origin_x);
			REG_ORIGIN_Y:     prdata = DataWidth'(cfg_q.origin_y);
			REG_ORIGIN_Z:     prdata = DataWidth'(cfg_q.origin_z);
			REG_SIZE_X:       prdata = DataWidth'(cfg_q.size_x);
			REG_SIZE_Y:       prdata = DataWidth'(cfg_q.size_y);
			REG_SIZE_Z:       prdata = DataWidth'(cfg_q.size_z);
			REG_DIR_NEGATIVE: prdata = DataWidth'(cfg_q.dir_negative);
			default:          prdata = '0;
		endcase
	end

endmodule

// ----- sv/wbog_step.sv -----
// wbog_step: input register, front and wave end state, one origin computed per beat
// depends on wbog_pkg

module wbog_step (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wbog_pkg::cfg_t       cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 in_restart,
	input  wbog_pkg::off_t       in_off_x,
	input  wbog_pkg::off_t       in_off_y,
	input  wbog_pkg::off_t       in_off_z,
	input  logic                 in_last,
	output logic                 out_valid,
	input  logic                 out_ready,
	output wbog_pkg::res_t       out_res
);
	import wbog_pkg::*;

	logic   valid_s1;
	logic   restart_s1;
	off_t   off_x_s1, off_y_s1, off_z_s1;
	logic   last_s1;
	logic   fire;

	coord_t front_x_q, front_y_q, front_z_q;
	coord_t end_x_q, end_y_q, end_z_q;
	off_t   lat_x_q, lat_y_q;

	coord_t fx0, fy0, fz0, ex0, ey0, ez0;
	off_t   lx0, ly0;
	coord_t fx1, fy1, fz1, ex1, ey1, ez1;
	off_t   lx1, ly1;
	wide_t  zstep;
	logic   past;
	logic   leave;

	assign in_ready  = !valid_s1 || out_ready;
	assign fire      = valid_s1 && out_ready;
	assign out_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			restart_s1 <= in_restart;
			off_x_s1   <= in_off_x;
			off_y_s1   <= in_off_y;
			off_z_s1   <= in_off_z;
			last_s1    <= in_last;
		end
	end

	always_comb begin
		zstep = cfg.dir_negative ? -StepW : StepW;

		// restart: wave end reset and new front before emitting
		if (restart_s1) begin
			ex0 = coord_t'(uext(cfg.size_x));
			ey0 = coord_t'(uext(cfg.size_y));
			ez0 = end_z_reset(cfg.size_z, cfg.dir_negative);
			fx0 = front_coord(cfg.origin_x, off_x_s1, cfg.size_x);
			fy0 = front_coord(cfg.origin_y, off_y_s1, cfg.size_y);
			fz0 = front_coord(cfg.origin_z, off_z_s1, cfg.size_z);
			lx0 = off_x_s1;
			ly0 = off_y_s1;
		end else begin
			ex0 = end_x_q;
			ey0 = end_y_q;
			ez0 = end_z_q;
			fx0 = front_x_q;
			fy0 = front_y_q;
			fz0 = front_z_q;
			lx0 = lat_x_q;
			ly0 = lat_y_q;
		end

		out_res.block_x   = to_out(fx0);
		out_res.block_y   = to_out(fy0);
		out_res.block_z   = to_out(fz0);
		out_res.batch_end = last_s1;

		// advance x, then y, then z
		fx1 = coord_t'(cext(fx0) + StepW);
		fy1 = fy0;
		fz1 = fz0;
		if (fx1 > ex0) begin
			fx1 = coord_t'(oext(lx0));
			fy1 = coord_t'(cext(fy0) + StepW);
		end
		if (fy1 > ey0) begin
			fy1 = coord_t'(oext(ly0));
			fz1 = coord_t'(cext(fz0) + zstep);
		end
		past = cfg.dir_negative ? (fz1 < ez0) : (fz1 > ez0);

		ex1   = ex0;
		ey1   = ey0;
		ez1   = ez0;
		lx1   = lx0;
		ly1   = ly0;
		leave = 1'b0;
		if (past) begin
			ez1   = coord_t'(cext(ez0) + zstep);
			leave = (cext(ex1) > uext(cfg.size_x) + StepW) ||
				(cext(ey1) > uext(cfg.size_y) + StepW) ||
				(cext(ez1) > uext(cfg.size_z) + StepW) ||
				(cext(ex1) <= -StepW) || (cext(ey1) <= -StepW) ||
				(cext(ez1) <= -StepW);
			if (leave) begin
				ex1 = coord_t'(uext(cfg.size_x));
				ey1 = coord_t'(uext(cfg.size_y));
				ez1 = end_z_reset(cfg.size_z, cfg.dir_negative);
			end
			fx1 = front_coord(cfg.origin_x, off_x_s1, cfg.size_x);
			fy1 = front_coord(cfg.origin_y, off_y_s1, cfg.size_y);
			fz1 = front_coord(cfg.origin_z, off_z_s1, cfg.size_z);
			lx1 = off_x_s1;
			ly1 = off_y_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_x_q <= '0;
			front_y_q <= '0;
			front_z_q <= '0;
			end_x_q   <= '0;
			end_y_q   <= '0;
			end_z_q   <= '0;
			lat_x_q   <= '0;
			lat_y_q   <= '0;
		end else if (fire) begin
			front_x_q <= fx1;
			front_y_q <= fy1;
			front_z_q <= fz1;
			end_x_q   <= ex1;
			end_y_q   <= ey1;
			end_z_q   <= ez1;
			lat_x_q   <= lx1;
			lat_y_q   <= ly1;
		end
	end

`ifndef SYNTHESIS
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(front_x_q) && $stable(front_y_q) && $stable(front_z_q) &&
			$stable(end_z_q))
		else $error("front or wave end moved without a beat");

	a_restart_end_x: assert property (@(posedge clk) disable iff (!arst_n)
		fire && restart_s1 |=> end_x_q == coord_t'(uext($past(cfg.size_x))))
		else $error("restart did not reset wave end x");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_ready |=> valid_s1 && $stable(restart_s1) && $stable(last_s1))
		else $error("stalled item lost from input stage");
`endif

endmodule

// ----- sv/wbog_out.sv -----
// wbog_out: result register between the origin logic and the output stream
// depends on wbog_pkg

module wbog_out (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  wbog_pkg::res_t in_res,
	output logic           m_valid,
	input  logic           m_ready,
	output wbog_pkg::res_t m_res
);
	import wbog_pkg::*;

	logic valid_q;
	res_t res_q;

	assign in_ready = !valid_q || m_ready;
	assign m_valid  = valid_q;
	assign m_res    = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			res_q <= in_res;
		end
	end

`ifndef SYNTHESIS
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> m_valid && m_res == $past(in_res))
		else $error("result beat not loaded");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid && m_ready && !in_valid |=> !m_valid)
		else $error("result beat repeated");
`endif

endmodule

// ----- sv/wave_block_origin_generator_top.sv -----
// path: an accepted input beat is registered in the input stage, then in the result register
// throughput: one origin per cycle unless m_axis stalls; fronts and wave end update once per beat
// the input stage and result register each hold one beat, so input is taken while a result waits
// reset: arst_n clears valid flags, config, fronts, wave end and latched offsets to zero at once
// top level of the wave block origin generator: apb config, step logic, result register
// depends on wbog_pkg, wbog_cfg, wbog_step, wbog_out

module wave_block_origin_generator_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [wbog_pkg::AddrWidth-1:0]    paddr,
	input  logic [wbog_pkg::DataWidth-1:0]    pwdata,
	output logic [wbog_pkg::DataWidth-1:0]    prdata,
	output logic                              pready,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// offset_x, offset_y, offset_z, zero pad
	input  logic [wbog_pkg::InDataWidth-1:0]  s_axis_tdata,
	// restart
	input  logic                              s_axis_tuser,
	input  logic                              s_axis_tlast,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// block_x, block_y, block_z, zero pad
	output logic [wbog_pkg::OutDataWidth-1:0] m_axis_tdata,
	output logic                              m_axis_tlast
);
	import wbog_pkg::*;

	cfg_t cfg;
	logic step_valid;
	logic step_ready;
	res_t step_res;
	res_t m_res;

	wbog_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	wbog_step u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_restart (s_axis_tuser),
		.in_off_x   (off_t'(s_axis_tdata[OffWidth-1:0])),
		.in_off_y   (off_t'(s_axis_tdata[2*OffWidth-1:OffWidth])),
		.in_off_z   (off_t'(s_axis_tdata[3*OffWidth-1:2*OffWidth])),
		.in_last    (s_axis_tlast),
		.out_valid  (step_valid),
		.out_ready  (step_ready),
		.out_res    (step_res)
	);

	wbog_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (step_valid),
		.in_ready (step_ready),
		.in_res   (step_res),
		.m_valid  (m_axis_tvalid),
		.m_ready  (m_axis_tready),
		.m_res    (m_res)
	);

	assign m_axis_tdata = OutDataWidth'({m_res.block_z, m_res.block_y, m_res.block_x});
	assign m_axis_tlast = m_res.batch_end;

endmodule

// ----- sim/wbog_checker.sv -----
// wbog_checker: watches the config port and both streams of the wave block origin generator,
// predicts every origin beat from its own copy of the wave state and compares field by field
// depends on wbog_pkg; reports a failure count and the number of origins still awaited

module wbog_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic                              pready,
	input  logic [wbog_pkg::AddrWidth-1:0]    paddr,
	input  logic [wbog_pkg::DataWidth-1:0]    pwdata,
	input  logic                              s_axis_tvalid,
	input  logic                              s_axis_tready,
	// offset_x, offset_y, offset_z, zero pad
	input  logic [wbog_pkg::InDataWidth-1:0]  s_axis_tdata,
	// restart
	input  logic                              s_axis_tuser,
	input  logic                              s_axis_tlast,
	input  logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// block_x, block_y, block_z, zero pad
	input  logic [wbog_pkg::OutDataWidth-1:0] m_axis_tdata,
	input  logic                              m_axis_tlast,
	output int                                errors,
	output int unsigned                       pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import wbog_pkg::*;

	cfg_t regs;
	int   fx, fy, fz;
	int   ex, ey, ez;
	int   lat_x, lat_y;
	off_t ox, oy, oz;
	res_t expected_origins[$];
	res_t want;
	res_t got;

	initial errors = 0;

	function automatic int to_coord(int v);
		coord_t c;
		c = coord_t'(v);
		return int'(c);
	endfunction

	function automatic int z_step();
		return regs.dir_negative ? -BlockStep : BlockStep;
	endfunction

	function automatic void reset_wave_end();
		ex = to_coord(int'(regs.size_x));
		ey = to_coord(int'(regs.size_y));
		ez = regs.dir_negative ? to_coord(int'(regs.size_z) - BlockStep) : to_coord(BlockStep);
	endfunction

	function automatic void advance_wave_end();
		ez = to_coord(ez + z_step());
		if (ex > int'(regs.size_x) + BlockStep || ey > int'(regs.size_y) + BlockStep ||
			ez > int'(regs.size_z) + BlockStep) begin
			reset_wave_end();
		end
		if (ex <= -BlockStep || ey <= -BlockStep || ez <= -BlockStep) begin
			reset_wave_end();
		end
	endfunction

	function automatic int front_start(cfg_val_t org, int off, cfg_val_t sz);
		int v;
		v = int'(org) + off;
		if (v > int'(sz)) begin
			v = int'(org);
		end
		return to_coord(v);
	endfunction

	function automatic void form_front(int dx, int dy, int dz);
		lat_x = dx;
		lat_y = dy;
		fx = front_start(regs.origin_x, dx, regs.size_x);
		fy = front_start(regs.origin_y, dy, regs.size_y);
		fz = front_start(regs.origin_z, dz, regs.size_z);
	endfunction

	function automatic res_t next_origin(logic restart, int dx, int dy, int dz, logic last);
		res_t r;
		bit   past;
		if (restart) begin
			reset_wave_end();
			form_front(dx, dy, dz);
		end
		r.block_x   = OutWidth'(fx);
		r.block_y   = OutWidth'(fy);
		r.block_z   = OutWidth'(fz);
		r.batch_end = last;
		fx = to_coord(fx + BlockStep);
		if (fx > ex) begin
			fx = to_coord(lat_x);
			fy = to_coord(fy + BlockStep);
		end
		if (fy > ey) begin
			fy = to_coord(lat_y);
			fz = to_coord(fz + z_step());
		end
		past = regs.dir_negative ? (fz < ez) : (fz > ez);
		if (past) begin
			advance_wave_end();
			form_front(dx, dy, dz);
		end
		return r;
	endfunction

	task automatic report(string msg);
		$display("%0t ns  %s", $realtime, msg);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = '0;
			fx = 0;
			fy = 0;
			fz = 0;
			ex = 0;
			ey = 0;
			ez = 0;
			lat_x = 0;
			lat_y = 0;
			expected_origins.delete();
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[AddrWidth-1:2]))
					REG_ORIGIN_X:     regs.origin_x = pwdata[CfgWidth-1:0];
					REG_ORIGIN_Y:     regs.origin_y = pwdata[CfgWidth-1:0];
					REG_ORIGIN_Z:     regs.origin_z = pwdata[CfgWidth-1:0];
					REG_SIZE_X:       regs.size_x = pwdata[CfgWidth-1:0];
					REG_SIZE_Y:       regs.size_y = pwdata[CfgWidth-1:0];
					REG_SIZE_Z:       regs.size_z = pwdata[CfgWidth-1:0];
					REG_DIR_NEGATIVE: regs.dir_negative = pwdata[0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.block_x   = m_axis_tdata[OutWidth-1:0];
				got.block_y   = m_axis_tdata[2*OutWidth-1:OutWidth];
				got.block_z   = m_axis_tdata[3*OutWidth-1:2*OutWidth];
				got.batch_end = m_axis_tlast;
				if (expected_origins.size() == 0) begin
					report($sformatf("origin beat x %03h y %03h z %03h with none due",
						got.block_x, got.block_y, got.block_z));
				end else begin
					want = expected_origins.pop_front();
					if (got.block_x !== want.block_x) begin
						report($sformatf("block_x %03h, predicted %03h", got.block_x, want.block_x));
					end
					if (got.block_y !== want.block_y) begin
						report($sformatf("block_y %03h, predicted %03h", got.block_y, want.block_y));
					end
					if (got.block_z !== want.block_z) begin
						report($sformatf("block_z %03h, predicted %03h", got.block_z, want.block_z));
					end
					if (got.batch_end !== want.batch_end) begin
						report($sformatf("batch_end %b, predicted %b", got.batch_end, want.batch_end));
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				ox = s_axis_tdata[OffWidth-1:0];
				oy = s_axis_tdata[2*OffWidth-1:OffWidth];
				oz = s_axis_tdata[3*OffWidth-1:2*OffWidth];
				expected_origins.push_back(next_origin(s_axis_tuser, int'(ox), int'(oy), int'(oz),
					s_axis_tlast));
			end
			pending = expected_origins.size();
		end
	end

endmodule

// ----- sim/testbench.sv -----
// testbench: drives config writes and origin requests into the wave block origin generator
// with random gaps and stalls on both streams; depends on wbog_pkg, the block and wbog_checker

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import wbog_pkg::*;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    psel = 1'b0;
	logic                    penable = 1'b0;
	logic                    pwrite = 1'b0;
	logic [AddrWidth-1:0]    paddr = '0;
	logic [DataWidth-1:0]    pwdata = '0;
	logic [DataWidth-1:0]    prdata;
	logic                    pready;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [InDataWidth-1:0]  s_axis_tdata = '0;
	logic                    s_axis_tuser = 1'b0;
	logic                    s_axis_tlast = 1'b0;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [OutDataWidth-1:0] m_axis_tdata;
	logic                    m_axis_tlast;
	int                      errors;
	int unsigned             pending;
	int                      requests_sent = 0;
	int                      restarts_sent = 0;
	int                      phases_run = 0;
	bit                      steady = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	wave_block_origin_generator_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	wbog_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.errors        (errors),
		.pending       (pending)
	);

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [1:0] pick_offset();
		if ($urandom_range(0, 7) == 0) return 2'b10;
		case ($urandom_range(0, 2))
			0:       return 2'b11;
			1:       return 2'b00;
			default: return 2'b01;
		endcase
	endfunction

	task automatic apb_write(reg_idx_t idx, cfg_val_t val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= AddrWidth'(4 * int'(idx));
		pwdata <= DataWidth'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_wave(cfg_val_t ox, cfg_val_t oy, cfg_val_t oz,
		cfg_val_t sx, cfg_val_t sy, cfg_val_t sz, logic dir);
		apb_write(REG_ORIGIN_X, ox);
		apb_write(REG_ORIGIN_Y, oy);
		apb_write(REG_ORIGIN_Z, oz);
		apb_write(REG_SIZE_X, sx);
		apb_write(REG_SIZE_Y, sy);
		apb_write(REG_SIZE_Z, sz);
		apb_write(REG_DIR_NEGATIVE, cfg_val_t'(dir));
		phases_run++;
	endtask

	task automatic send_request(logic restart, logic [1:0] ox, logic [1:0] oy, logic [1:0] oz,
		logic last);
		int gap;
		gap = steady ? 0 : idle_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= InDataWidth'({oz, oy, ox});
		s_axis_tuser <= restart;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		requests_sent++;
		if (restart) restarts_sent++;
	endtask

	// stop offering and let every predicted origin come out
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	// receiver: short random stalls, calm stretches, one long hold-off
	initial begin
		int  taken;
		int  gap;
		bit  held;
		bit  calm;
		taken = 0;
		held = 1'b0;
		calm = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) taken++;
			if ($urandom_range(0, 63) == 0) calm = !calm;
			if (!held && taken >= 300) begin
				held = 1'b1;
				gap = 250;
			end else begin
				gap = calm ? 0 : idle_len();
			end
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	initial begin
		#8_000_000;
		$display("timeout with %0d origins awaited", pending);
		$display("Mismatches found");
		$finish;
	end

	initial begin
		cfg_val_t o[3];
		cfg_val_t sz[3];
		logic     dir;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sweep from the all-zero state with no restart
		send_request(1'b0, 2'b00, 2'b00, 2'b00, 1'b0);
		send_request(1'b0, 2'b01, 2'b01, 2'b01, 1'b1);
		send_request(1'b0, 2'b11, 2'b11, 2'b11, 1'b0);
		drain();

		// tiny +z volume: every beat steps to the next z slab, wave end advances, leaves and resets
		set_wave(10'd1, 10'd1, 10'd1, 10'd4, 10'd4, 10'd8, 1'b0);
		send_request(1'b1, 2'b00, 2'b00, 2'b00, 1'b0);
		send_request(1'b0, 2'b01, 2'b01, 2'b01, 1'b1);
		send_request(1'b0, 2'b11, 2'b11, 2'b11, 1'b0);
		send_request(1'b0, 2'b10, 2'b10, 2'b10, 1'b0);
		send_request(1'b1, 2'b01, 2'b11, 2'b10, 1'b1);
		send_request(1'b0, 2'b00, 2'b00, 2'b00, 1'b0);
		send_request(1'b0, 2'b00, 2'b00, 2'b00, 1'b0);
		drain();

		// -z wave with the wave end running down to zero
		set_wave(10'd2, 10'd2, 10'd20, 10'd8, 10'd8, 10'd24, 1'b1);
		send_request(1'b1, 2'b00, 2'b00, 2'b00, 1'b1);
		send_request(1'b0, 2'b01, 2'b01, 2'b01, 1'b0);
		send_request(1'b0, 2'b11, 2'b11, 2'b11, 1'b0);
		send_request(1'b0, 2'b10, 2'b10, 2'b10, 1'b0);
		send_request(1'b0, 2'b00, 2'b00, 2'b00, 1'b0);
		send_request(1'b1, 2'b01, 2'b01, 2'b01, 1'b1);
		drain();

		// largest origin and size: positive offsets fall back to the origin
		set_wave(10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b1);
		send_request(1'b1, 2'b01, 2'b01, 2'b01, 1'b0);
		send_request(1'b1, 2'b10, 2'b10, 2'b10, 1'b1);
		send_request(1'b0, 2'b00, 2'b00, 2'b00, 1'b0);
		drain();

		for (int p = 0; p < 12; p++) begin
			case (p)
				0: begin
					o = '{10'd1023, 10'd1023, 10'd1023};
					sz = '{10'd1023, 10'd1023, 10'd1023};
					dir = 1'b0;
				end
				1: begin
					o = '{10'd0, 10'd0, 10'd0};
					sz = '{10'd0, 10'd0, 10'd0};
					dir = 1'b1;
				end
				2: begin
					o = '{10'd1023, 10'd1023, 10'd1023};
					sz = '{10'd0, 10'd0, 10'd0};
					dir = 1'b0;
				end
				default: begin
					for (int k = 0; k < 3; k++) begin
						o[k] = ($urandom_range(0, 4) == 0) ? 10'($urandom) : 10'($urandom_range(0, 24));
						sz[k] = ($urandom_range(0, 4) == 0) ? 10'($urandom) : 10'($urandom_range(0, 40));
					end
					dir = 1'($urandom_range(0, 1));
				end
			endcase
			set_wave(o[0], o[1], o[2], sz[0], sz[1], sz[2], dir);
			steady = (p % 4 == 3);
			for (int i = 0; i < 120; i++) begin
				send_request(i == 0 || $urandom_range(0, 29) == 0, pick_offset(), pick_offset(),
					pick_offset(), $urandom_range(0, 5) == 0);
			end
			steady = 1'b0;
			drain();
		end

		repeat (20) @(posedge clk);
		$display("sent %0d origin requests (%0d restarts) over %0d register settings",
			requests_sent, restarts_sent, phases_run);
		$display("both wave directions, all offset patterns, extreme origins and sizes, long stall");
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
